// ===== rtl/mbtrie_pkg.sv =====
// shared types and constants for the stride-2 multibit trie prefix lookup
// used by mbtrie_node_mem, mbtrie_walk and multibit_trie_prefix_lookup_top
package mbtrie_pkg;

    // node memory geometry
    localparam int NODES  = 4096;
    localparam int IDX_W  = $clog2(NODES);
    localparam int FREE_W = IDX_W + 1;

    // walk limits
    localparam int MAX_LEN    = 32;
    localparam int MAX_LEVELS = 16;
    localparam int LVL_W      = 5;
    localparam int LEN_W      = 6;
    localparam int PORT_W     = 7;

    // operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [FREE_W-1:0] free_t;
    typedef logic [LVL_W-1:0]  lvl_t;

    // stored port: valid flag over the port number
    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] num;
    } port_t;

    // one trie node: four child links and an optional port
    typedef struct packed {
        idx_t [3:0] link;
        port_t      port;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // node memory request from the walker
    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        node_t wr_data;
    } mem_req_t;

    typedef struct packed {
        logic              mode;
        logic [31:0]       address;
        logic [LEN_W-1:0]  prefix_len;
        logic [PORT_W-1:0] new_port;
    } in_item_t;

    typedef struct packed {
        logic [PORT_W-1:0] found_port;
        logic              hit;
        logic              pool_full;
    } out_item_t;

endpackage

// ===== rtl/multibit_trie_prefix_lookup_top.sv =====
// top level of the stride-2 multibit trie longest-prefix-match engine
// instantiates mbtrie_walk and mbtrie_node_mem, holds the output register; uses mbtrie_pkg
//
//   channel   | signals                         | payload
//   ----------+---------------------------------+-----------------------------
//   input     | in_valid / in_stall             | in_item  (mode, address,
//             |                                 |          prefix_len, new_port)
//   output    | out_valid / out_stall           | out_item (found_port, hit,
//             |                                 |          pool_full)
//
// one item at a time, one node memory read per trie level on the node memory read port
// a lookup follows child links until a link is missing or MAX_LEVELS levels are descended
// an insert checks and writes back each level, with a sibling step on the last level of an
// odd length, reading an existing sibling; reset empties the root, node 1 is next free
// a finished result waits in the output register while the next item is taken;
// the walk holds in its last state only when that register is still full and stalled
module multibit_trie_prefix_lookup_top
    import mbtrie_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    mem_req_t  mem_req;
    node_t     rd_data;
    logic      res_valid;
    logic      res_ready;
    out_item_t res;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    mbtrie_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    mbtrie_node_mem u_node_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // output register accepts a result when empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/mbtrie_node_mem.sv =====
// trie node memory: one write port, one read port, registered read data
// the root reads as an empty node until it is first written; uses mbtrie_pkg
module mbtrie_node_mem
    import mbtrie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output node_t    rd_data
);

    logic [NODE_W-1:0] mem [NODES];
    logic [NODE_W-1:0] rd_q;
    logic              root_ok_reg;
    logic              rd_blank_reg;

    // array write and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q <= mem[req.rd_addr];
        end
    end

    // root tracking: an unwritten root reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_ok_reg  <= 1'b0;
            rd_blank_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en && req.wr_addr == '0)
            begin
                root_ok_reg <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_blank_reg <= (req.rd_addr == '0) && !root_ok_reg;
            end
        end
    end

    assign rd_data = rd_blank_reg ? node_t'('0) : node_t'(rd_q);

endmodule

// ===== rtl/mbtrie_walk.sv =====
// trie walk sequencer for insert and lookup, one node read per level
// drives the node memory and the bump allocator; uses mbtrie_pkg
module mbtrie_walk
    import mbtrie_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res,
    output mem_req_t  mem_req,
    input  node_t     rd_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LCHK,
        S_ICHK,
        S_ISIB,
        S_ISRD,
        S_IWB,
        S_FCHK,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic              mode_reg, mode_next;
    logic [31:0]       addr_reg, addr_next;
    lvl_t              levels_reg, levels_next;
    logic              odd_reg, odd_next;
    port_t             pv_reg, pv_next;
    lvl_t              lvl_reg, lvl_next;
    idx_t              cur_reg, cur_next;
    idx_t              nxt_reg, nxt_next;
    node_t             node_reg, node_next;
    logic              dirty_reg, dirty_next;
    logic              fail_reg, fail_next;
    free_t             free_reg, free_next;
    logic [PORT_W-1:0] best_reg, best_next;
    logic              found_reg, found_next;

    logic [1:0]        pair;
    logic [1:0]        sib;
    logic              last_lvl;
    logic              pool_empty;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  len_inc;
    idx_t              lnk;

    assign pair       = addr_reg[31:30];
    assign sib        = pair ^ 2'b01;
    assign last_lvl   = (lvl_reg + lvl_t'(1)) == levels_reg;
    assign pool_empty = free_reg == free_t'(NODES);
    assign len_sat    = (in_item.prefix_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                               : in_item.prefix_len;
    assign len_inc    = len_sat + LEN_W'(1);
    assign lnk        = rd_data.link[pair];

    assign in_stall  = state_reg != S_IDLE;
    assign res_valid = state_reg == S_DONE;

    // result fields by operation
    always_comb
    begin
        res = '0;
        if (mode_reg == MODE_LOOKUP)
        begin
            res.found_port = best_reg;
            res.hit        = found_reg;
        end
        else
        begin
            res.pool_full = fail_reg;
        end
    end

    // walk sequencing and memory requests
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        addr_next   = addr_reg;
        levels_next = levels_reg;
        odd_next    = odd_reg;
        pv_next     = pv_reg;
        lvl_next    = lvl_reg;
        cur_next    = cur_reg;
        nxt_next    = nxt_reg;
        node_next   = node_reg;
        dirty_next  = dirty_reg;
        fail_next   = fail_reg;
        free_next   = free_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        mem_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = in_item.mode;
                    addr_next   = in_item.address;
                    levels_next = lvl_t'(len_inc >> 1);
                    odd_next    = len_sat[0];
                    pv_next     = '{valid: 1'b1, num: in_item.new_port};
                    lvl_next    = '0;
                    cur_next    = '0;
                    dirty_next  = 1'b0;
                    fail_next   = 1'b0;
                    best_next   = '0;
                    found_next  = 1'b0;
                    state_next  = S_READ;
                end
            end

            // read the current node
            S_READ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cur_reg;
                if (mode_reg == MODE_LOOKUP)
                begin
                    state_next = S_LCHK;
                end
                else if (levels_reg == '0)
                begin
                    state_next = S_FCHK;
                end
                else
                begin
                    state_next = S_ICHK;
                end
            end

            // lookup: note the port, then follow the child or stop
            S_LCHK:
            begin
                if (rd_data.port.valid)
                begin
                    best_next  = rd_data.port.num;
                    found_next = 1'b1;
                end
                if (lvl_reg == lvl_t'(MAX_LEVELS) || lnk == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = lnk;
                    cur_next        = lnk;
                    addr_next       = addr_reg << 2;
                    lvl_next        = lvl_reg + lvl_t'(1);
                end
            end

            // insert: take or allocate the path child
            S_ICHK:
            begin
                node_next  = rd_data;
                dirty_next = 1'b0;
                if (lnk == '0)
                begin
                    if (pool_empty)
                    begin
                        fail_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_req.wr_en        = 1'b1;
                        mem_req.wr_addr      = free_reg[IDX_W-1:0];
                        mem_req.wr_data      = '0;
                        node_next.link[pair] = free_reg[IDX_W-1:0];
                        nxt_next             = free_reg[IDX_W-1:0];
                        free_next            = free_reg + free_t'(1);
                        dirty_next           = 1'b1;
                        state_next           = (last_lvl && odd_reg) ? S_ISIB : S_IWB;
                    end
                end
                else
                begin
                    nxt_next   = lnk;
                    state_next = (last_lvl && odd_reg) ? S_ISIB : S_IWB;
                end
            end

            // odd length: sibling child gets the port when absent or empty
            S_ISIB:
            begin
                if (node_reg.link[sib] == '0)
                begin
                    if (pool_empty)
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        mem_req.wr_en           = 1'b1;
                        mem_req.wr_addr         = free_reg[IDX_W-1:0];
                        mem_req.wr_data         = '0;
                        mem_req.wr_data.port    = pv_reg;
                        node_next.link[sib]     = free_reg[IDX_W-1:0];
                        free_next               = free_reg + free_t'(1);
                        dirty_next              = 1'b1;
                    end
                    state_next = S_IWB;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = node_reg.link[sib];
                    state_next      = S_ISRD;
                end
            end

            // existing sibling: fill its port if empty
            S_ISRD:
            begin
                if (!rd_data.port.valid)
                begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = node_reg.link[sib];
                    mem_req.wr_data      = rd_data;
                    mem_req.wr_data.port = pv_reg;
                end
                state_next = S_IWB;
            end

            // write back the current node if changed, then descend unless the insert failed
            S_IWB:
            begin
                if (dirty_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = cur_reg;
                    mem_req.wr_data = node_reg;
                end
                if (fail_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = nxt_reg;
                    cur_next        = nxt_reg;
                    addr_next       = addr_reg << 2;
                    lvl_next        = lvl_reg + lvl_t'(1);
                    state_next      = last_lvl ? S_FCHK : S_ICHK;
                end
            end

            // final node takes the port on even length or when empty
            S_FCHK:
            begin
                if (!odd_reg || !rd_data.port.valid)
                begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = cur_reg;
                    mem_req.wr_data      = rd_data;
                    mem_req.wr_data.port = pv_reg;
                end
                state_next = S_DONE;
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered walk context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            free_reg   <= free_t'(1);
            mode_reg   <= MODE_INSERT;
            fail_reg   <= 1'b0;
            found_reg  <= 1'b0;
            best_reg   <= '0;
            dirty_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            free_reg   <= free_next;
            mode_reg   <= mode_next;
            fail_reg   <= fail_next;
            found_reg  <= found_next;
            best_reg   <= best_next;
            dirty_reg  <= dirty_next;
        end
    end

    // walk payload
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        levels_reg <= levels_next;
        odd_reg    <= odd_next;
        pv_reg     <= pv_next;
        lvl_reg    <= lvl_next;
        cur_reg    <= cur_next;
        nxt_reg    <= nxt_next;
        node_reg   <= node_next;
    end

endmodule
